FILE: hw/rtl/ttpc_pkg.sv
// Shared types and constants for the timestamp tolerant power combiner.
// No dependencies; imported by the frame cell, the top level and the testbench files.
package ttpc_pkg;

  localparam int TIME_W  = 64;
  localparam int SUB_W   = 16;
  localparam int POW_W   = 32;
  localparam int EXPO_W  = 32;
  localparam int NOISE_W = 8;
  localparam int SUM_W   = 48;
  localparam int EXP_W   = 5;
  localparam int TOL_W   = 20;
  localparam int CFG_W   = 20;

  localparam int OPEN_FRAMES_DEF  = 16;
  localparam int MAX_SUBBANDS_DEF = 16;

  localparam logic [EXP_W-1:0] EXPECTED_RESET  = 5'd8;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 20'd1000;
  localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};

  typedef logic [2:0] status_t;

  localparam status_t ST_OPENED    = 3'd0;
  localparam status_t ST_MERGED    = 3'd1;
  localparam status_t ST_COMPLETED = 3'd2;
  localparam status_t ST_DUPLICATE = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_BAD       = 3'd5;

  typedef logic [0:0] reg_index_t;
  localparam reg_index_t REG_EXPECTED  = 1'b0;
  localparam reg_index_t REG_TOLERANCE = 1'b1;

endpackage

FILE: hw/rtl/timestamp_tolerant_power_combiner.sv
// Top level of the timestamp tolerant power combiner: a row of frame cells,
// the match/update sequencer and the output register. Depends on ttpc_pkg, ttpc_cell.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   in        | in_valid / in_ready  | arrival_time subband power exposure noise_flag
//   out       | out_valid / out_ready| status frame_time frame_power frame_exposure
//             |                      | frame_noise
//   cfg       | cfg_we               | cfg_index cfg_data
//
// After a word is accepted, the search word walks the cell row one cell per cycle;
// then the decide step picks the matching frame and the update step updates the
// entry and loads the output register. Reset clears all entry valid bits at once.
// A stalled output holds the sequencer in its update step; the next word is taken
// once the previous one has reached the output register.
module timestamp_tolerant_power_combiner
  import ttpc_pkg::*;
#(
  parameter int OPEN_FRAMES  = OPEN_FRAMES_DEF,
  parameter int MAX_SUBBANDS = MAX_SUBBANDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TIME_W-1:0]   arrival_time,
  input  logic [SUB_W-1:0]    subband,
  input  logic [POW_W-1:0]    power,
  input  logic [EXPO_W-1:0]   exposure,
  input  logic [NOISE_W-1:0]  noise_flag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [TIME_W-1:0]   frame_time,
  output logic [SUM_W-1:0]    frame_power,
  output logic [EXPO_W-1:0]   frame_exposure,
  output logic [NOISE_W-1:0]  frame_noise,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int IDX_W  = (OPEN_FRAMES > 1) ? $clog2(OPEN_FRAMES) : 1;
  localparam int SB_W   = (MAX_SUBBANDS > 1) ? $clog2(MAX_SUBBANDS) : 1;
  localparam int MASK_W = MAX_SUBBANDS;
  localparam int CNT_W  = ($clog2(MAX_SUBBANDS + 1) > EXP_W) ?
                          $clog2(MAX_SUBBANDS + 1) : EXP_W;
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(OPEN_FRAMES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]         state;
  logic [IDX_W-1:0]   scan_cnt;

  logic [EXP_W-1:0]   expected;
  logic [TOL_W-1:0]   tolerance;

  logic [TIME_W-1:0]  time_r;
  logic [SUB_W-1:0]   sub_r;
  logic [POW_W-1:0]   pow_r;
  logic [EXPO_W-1:0]  expo_r;
  logic [NOISE_W-1:0] noise_r;

  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  // search chain, position OPEN_FRAMES is the tail
  logic               a_f [OPEN_FRAMES+1];
  logic [IDX_W-1:0]   a_i [OPEN_FRAMES+1];
  logic [TIME_W-1:0]  a_t [OPEN_FRAMES+1];
  logic               b_f [OPEN_FRAMES+1];
  logic [IDX_W-1:0]   b_i [OPEN_FRAMES+1];
  logic [TIME_W-1:0]  b_t [OPEN_FRAMES+1];
  logic               f_f [OPEN_FRAMES+1];
  logic [IDX_W-1:0]   f_i [OPEN_FRAMES+1];

  logic               e_valid [OPEN_FRAMES];
  logic [TIME_W-1:0]  e_time  [OPEN_FRAMES];
  logic [SUM_W-1:0]   e_sum   [OPEN_FRAMES];
  logic [MASK_W-1:0]  e_mask  [OPEN_FRAMES];
  logic [CNT_W-1:0]   e_count [OPEN_FRAMES];
  logic [EXPO_W-1:0]  e_expo  [OPEN_FRAMES];
  logic [NOISE_W-1:0] e_noise [OPEN_FRAMES];

  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_valid;
  logic [TIME_W-1:0]  wr_time;
  logic [SUM_W-1:0]   wr_sum;
  logic [MASK_W-1:0]  wr_mask;
  logic [CNT_W-1:0]   wr_count;
  logic [EXPO_W-1:0]  wr_expo;
  logic [NOISE_W-1:0] wr_noise;

  logic               upd_go;
  logic               bad;
  logic [MASK_W-1:0]  sb_bit;
  logic [EXP_W-1:0]   need;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [CNT_W-1:0]   cnt_inc;
  logic               done;
  logic [TIME_W-1:0]  diff_a;
  logic [TIME_W-1:0]  diff_b;
  logic               match_a;
  logic               match_b;

  status_t            status_next;
  logic [TIME_W-1:0]  time_next;
  logic [SUM_W-1:0]   sum_next;
  logic [EXPO_W-1:0]  expo_next;
  logic [NOISE_W-1:0] noise_next;

  // Empty search word enters the head of the row
  assign a_f[0] = 1'b0;
  assign a_i[0] = '0;
  assign a_t[0] = '0;
  assign b_f[0] = 1'b0;
  assign b_i[0] = '0;
  assign b_t[0] = '0;
  assign f_f[0] = 1'b0;
  assign f_i[0] = '0;

  for (genvar g = 0; g < OPEN_FRAMES; g++) begin : g_cell
    ttpc_cell #(
      .CELL_ID (g),
      .IDX_W   (IDX_W),
      .MASK_W  (MASK_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .item_time  (time_r),
      .a_found_in (a_f[g]),
      .a_idx_in   (a_i[g]),
      .a_time_in  (a_t[g]),
      .b_found_in (b_f[g]),
      .b_idx_in   (b_i[g]),
      .b_time_in  (b_t[g]),
      .f_found_in (f_f[g]),
      .f_idx_in   (f_i[g]),
      .a_found    (a_f[g+1]),
      .a_idx      (a_i[g+1]),
      .a_time     (a_t[g+1]),
      .b_found    (b_f[g+1]),
      .b_idx      (b_i[g+1]),
      .b_time     (b_t[g+1]),
      .f_found    (f_f[g+1]),
      .f_idx      (f_i[g+1]),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_valid   (wr_valid),
      .wr_time    (wr_time),
      .wr_sum     (wr_sum),
      .wr_mask    (wr_mask),
      .wr_count   (wr_count),
      .wr_expo    (wr_expo),
      .wr_noise   (wr_noise),
      .ent_valid  (e_valid[g]),
      .ent_time   (e_time[g]),
      .ent_sum    (e_sum[g]),
      .ent_mask   (e_mask[g]),
      .ent_count  (e_count[g]),
      .ent_expo   (e_expo[g]),
      .ent_noise  (e_noise[g])
    );
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected  <= EXPECTED_RESET;
      tolerance <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED:  expected  <= cfg_data[EXP_W-1:0];
        REG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign upd_go   = (state == S_UPDATE) && (!out_valid || out_ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          if (scan_cnt == SCAN_LAST) begin
            state <= S_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_DECIDE: state <= S_UPDATE;
        S_UPDATE: begin
          if (upd_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      time_r  <= arrival_time;
      sub_r   <= subband;
      pow_r   <= power;
      expo_r  <= exposure;
      noise_r <= noise_flag;
    end
  end

  // Pick the matching frame from the tail of the row
  assign diff_a  = a_t[OPEN_FRAMES] - time_r;
  assign diff_b  = time_r - b_t[OPEN_FRAMES];
  assign match_a = a_f[OPEN_FRAMES] && (diff_a <= {{(TIME_W-TOL_W){1'b0}}, tolerance});
  assign match_b = b_f[OPEN_FRAMES] && (diff_b <= {{(TIME_W-TOL_W){1'b0}}, tolerance});

  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      hit_found  <= match_a || match_b;
      hit_idx    <= match_a ? a_i[OPEN_FRAMES] : b_i[OPEN_FRAMES];
      free_found <= f_f[OPEN_FRAMES];
      free_idx   <= f_i[OPEN_FRAMES];
    end
  end

  // Update the hit entry or open a new one, or report a bad, duplicate or full word
  assign bad      = {1'b0, sub_r} >= (SUB_W+1)'(MAX_SUBBANDS);
  assign sb_bit   = MASK_W'(1) << sub_r[SB_W-1:0];
  assign need     = (expected == '0) ? EXP_W'(1) : expected;
  assign sum_wide = {1'b0, e_sum[hit_idx]} + (SUM_W+1)'(pow_r);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign cnt_inc  = e_count[hit_idx] + 1'b1;
  assign done     = (cnt_inc == CNT_W'(need));

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    wr_valid    = 1'b1;
    wr_time     = e_time[hit_idx];
    wr_sum      = sum_sat;
    wr_mask     = e_mask[hit_idx] | sb_bit;
    wr_count    = cnt_inc;
    wr_expo     = e_expo[hit_idx];
    wr_noise    = e_noise[hit_idx];
    status_next = ST_BAD;
    time_next   = '0;
    sum_next    = '0;
    expo_next   = '0;
    noise_next  = '0;
    if (bad) begin
      status_next = ST_BAD;
    end else if (!hit_found) begin
      time_next  = time_r;
      sum_next   = SUM_W'(pow_r);
      expo_next  = expo_r;
      noise_next = noise_r;
      if (need == EXP_W'(1)) begin
        status_next = ST_COMPLETED;
      end else if (!free_found) begin
        status_next = ST_FULL;
        time_next   = '0;
        sum_next    = '0;
        expo_next   = '0;
        noise_next  = '0;
      end else begin
        status_next = ST_OPENED;
        wr_en       = upd_go;
        wr_idx      = free_idx;
        wr_time     = time_r;
        wr_sum      = SUM_W'(pow_r);
        wr_mask     = sb_bit;
        wr_count    = CNT_W'(1);
        wr_expo     = expo_r;
        wr_noise    = noise_r;
      end
    end else begin
      time_next  = e_time[hit_idx];
      expo_next  = e_expo[hit_idx];
      noise_next = e_noise[hit_idx];
      if ((e_mask[hit_idx] & sb_bit) != '0) begin
        status_next = ST_DUPLICATE;
        sum_next    = e_sum[hit_idx];
      end else begin
        status_next = done ? ST_COMPLETED : ST_MERGED;
        sum_next    = sum_sat;
        wr_en       = upd_go;
        wr_valid    = !done;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      status         <= status_next;
      frame_time     <= time_next;
      frame_power    <= sum_next;
      frame_exposure <= expo_next;
      frame_noise    <= noise_next;
    end
  end

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN) && (scan_cnt == '0))
    else $error("accepted word did not start the cell scan");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_UPDATE))
    else $error("result appeared outside the update step");

  a_hit_is_open: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UPDATE) && hit_found) |-> e_valid[hit_idx])
    else $error("matched frame entry is not open");

  a_no_write_on_reject: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !bad && (status_next != ST_FULL) && (status_next != ST_DUPLICATE))
    else $error("entry written for a rejected word");

endmodule

FILE: hw/rtl/ttpc_cell.sv
// One frame cell: holds one open frame entry and refines the running search
// (nearest key at/after, nearest key before, first free slot) from its neighbor.
// Depends on ttpc_pkg.
module ttpc_cell
  import ttpc_pkg::*;
#(
  parameter int CELL_ID = 0,
  parameter int IDX_W   = 4,
  parameter int MASK_W  = 16,
  parameter int CNT_W   = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [TIME_W-1:0]   item_time,
  // search word from the left neighbor
  input  logic                a_found_in,
  input  logic [IDX_W-1:0]    a_idx_in,
  input  logic [TIME_W-1:0]   a_time_in,
  input  logic                b_found_in,
  input  logic [IDX_W-1:0]    b_idx_in,
  input  logic [TIME_W-1:0]   b_time_in,
  input  logic                f_found_in,
  input  logic [IDX_W-1:0]    f_idx_in,
  // registered search word to the right neighbor
  output logic                a_found,
  output logic [IDX_W-1:0]    a_idx,
  output logic [TIME_W-1:0]   a_time,
  output logic                b_found,
  output logic [IDX_W-1:0]    b_idx,
  output logic [TIME_W-1:0]   b_time,
  output logic                f_found,
  output logic [IDX_W-1:0]    f_idx,
  // entry write
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic                wr_valid,
  input  logic [TIME_W-1:0]   wr_time,
  input  logic [SUM_W-1:0]    wr_sum,
  input  logic [MASK_W-1:0]   wr_mask,
  input  logic [CNT_W-1:0]    wr_count,
  input  logic [EXPO_W-1:0]   wr_expo,
  input  logic [NOISE_W-1:0]  wr_noise,
  // entry contents
  output logic                ent_valid,
  output logic [TIME_W-1:0]   ent_time,
  output logic [SUM_W-1:0]    ent_sum,
  output logic [MASK_W-1:0]   ent_mask,
  output logic [CNT_W-1:0]    ent_count,
  output logic [EXPO_W-1:0]   ent_expo,
  output logic [NOISE_W-1:0]  ent_noise
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

  logic sel;
  logic take_a;
  logic take_b;
  logic take_f;

  assign sel = wr_en && (wr_idx == MY_IDX);

  // Store the entry; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (sel) begin
      ent_valid <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      ent_time  <= wr_time;
      ent_sum   <= wr_sum;
      ent_mask  <= wr_mask;
      ent_count <= wr_count;
      ent_expo  <= wr_expo;
      ent_noise <= wr_noise;
    end
  end

  // Compare own key against the running best on each side
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (ent_valid) begin
      if (ent_time >= item_time) begin
        take_a = !a_found_in || (ent_time < a_time_in);
      end else begin
        take_b = !b_found_in || (ent_time > b_time_in);
      end
    end
    take_f = !ent_valid && !f_found_in;
  end

  // Hand the refined search word on
  always_ff @(posedge clk) begin
    a_found <= a_found_in || take_a;
    a_idx   <= take_a ? MY_IDX : a_idx_in;
    a_time  <= take_a ? ent_time : a_time_in;
    b_found <= b_found_in || take_b;
    b_idx   <= take_b ? MY_IDX : b_idx_in;
    b_time  <= take_b ? ent_time : b_time_in;
    f_found <= f_found_in || take_f;
    f_idx   <= take_f ? MY_IDX : f_idx_in;
  end

endmodule

FILE: tb/ttpc_checker.sv
// Checker for the timestamp tolerant power combiner: watches the input, output and
// register ports, predicts each result word and compares it. Depends on ttpc_pkg.
`timescale 1ns / 100ps

module ttpc_checker
  import ttpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [TIME_W-1:0]      arrival_time,
  input  logic [SUB_W-1:0]       subband,
  input  logic [POW_W-1:0]       power,
  input  logic [EXPO_W-1:0]      exposure,
  input  logic [NOISE_W-1:0]     noise_flag,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [2:0]             status,
  input  logic [TIME_W-1:0]      frame_time,
  input  logic [SUM_W-1:0]       frame_power,
  input  logic [EXPO_W-1:0]      frame_exposure,
  input  logic [NOISE_W-1:0]     frame_noise,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     fails,
  output int                     pending,
  output logic [15:0]            open_valid,
  output logic [16*TIME_W-1:0]   open_keys,
  output logic [16*16-1:0]       open_masks
);

  typedef struct packed {
    status_t              st;
    logic [TIME_W-1:0]    t;
    logic [SUM_W-1:0]     sum;
    logic [EXPO_W-1:0]    expo;
    logic [NOISE_W-1:0]   noise;
  } frame_word_t;

  frame_word_t frame_words_due[$];

  // Shadow frame table and register copies
  logic               slot_live  [16];
  logic [TIME_W-1:0]  slot_key   [16];
  logic [SUM_W-1:0]   slot_sum   [16];
  logic [15:0]        slot_mask  [16];
  logic [4:0]         slot_count [16];
  logic [EXPO_W-1:0]  slot_expo  [16];
  logic [NOISE_W-1:0] slot_noise [16];
  logic [EXP_W-1:0]   need_reg;
  logic [TOL_W-1:0]   tol_reg;

  function automatic logic [TIME_W-1:0] time_gap(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t MISMATCH %s: got %0h want %0h", $time, what, got, want);
    fails++;
  endtask

  // Predict the result word for one accepted input word and update the table
  task automatic combine_word(input logic [TIME_W-1:0] t, input logic [SUB_W-1:0] sb,
                              input logic [POW_W-1:0] pw, input logic [EXPO_W-1:0] ex,
                              input logic [NOISE_W-1:0] nf, output frame_word_t r);
    int after, prior, hit, slot, i;
    logic [4:0] need;
    logic [15:0] bit_sel;
    logic [SUM_W:0] acc;
    r = '0;
    after = -1; prior = -1; hit = -1; slot = -1;
    need = (need_reg == 0) ? 5'd1 : need_reg;
    if (sb >= 16) begin
      r.st = ST_BAD;
    end else begin
      bit_sel = 16'd1 << sb[3:0];
      for (i = 0; i < 16; i++) begin
        if (slot_live[i]) begin
          if (slot_key[i] >= t) begin
            if (after < 0 || slot_key[i] < slot_key[after]) after = i;
          end else begin
            if (prior < 0 || slot_key[i] > slot_key[prior]) prior = i;
          end
        end
      end
      if (after >= 0 && time_gap(slot_key[after], t) <= tol_reg) hit = after;
      else if (prior >= 0 && time_gap(slot_key[prior], t) <= tol_reg) hit = prior;
      if (hit < 0) begin
        if (need == 1) begin
          r = '{ST_COMPLETED, t, {16'd0, pw}, ex, nf};
        end else begin
          for (i = 15; i >= 0; i--) if (!slot_live[i]) slot = i;
          if (slot < 0) begin
            r.st = ST_FULL;
          end else begin
            slot_live[slot]  = 1'b1;
            slot_key[slot]   = t;
            slot_sum[slot]   = {16'd0, pw};
            slot_mask[slot]  = bit_sel;
            slot_count[slot] = 5'd1;
            slot_expo[slot]  = ex;
            slot_noise[slot] = nf;
            r = '{ST_OPENED, t, {16'd0, pw}, ex, nf};
          end
        end
      end else if ((slot_mask[hit] & bit_sel) != 16'd0) begin
        r = '{ST_DUPLICATE, slot_key[hit], slot_sum[hit], slot_expo[hit], slot_noise[hit]};
      end else begin
        slot_mask[hit] = slot_mask[hit] | bit_sel;
        acc = {1'b0, slot_sum[hit]} + (SUM_W+1)'(pw);
        slot_sum[hit] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
        slot_count[hit] = slot_count[hit] + 5'd1;
        r = '{ST_MERGED, slot_key[hit], slot_sum[hit], slot_expo[hit], slot_noise[hit]};
        if (slot_count[hit] == need) begin
          slot_live[hit] = 1'b0;
          r.st = ST_COMPLETED;
        end
      end
    end
  endtask

  // Compare outgoing words, track register writes, predict incoming words
  always @(posedge clk) begin
    frame_word_t w;
    int i;
    if (rst) begin
      frame_words_due.delete();
      for (i = 0; i < 16; i++) begin
        slot_live[i] = 1'b0; slot_key[i] = '0; slot_sum[i] = '0; slot_mask[i] = '0;
        slot_count[i] = '0; slot_expo[i] = '0; slot_noise[i] = '0;
      end
      need_reg = EXPECTED_RESET;
      tol_reg  = TOLERANCE_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_words_due.size() == 0) begin
          flag_mismatch("unexpected word, status", 64'(status), 64'd0);
        end else begin
          w = frame_words_due.pop_front();
          if (status !== w.st) flag_mismatch("status", 64'(status), 64'(w.st));
          if (frame_time !== w.t) flag_mismatch("frame_time", frame_time, w.t);
          if (frame_power !== w.sum)
            flag_mismatch("frame_power", 64'(frame_power), 64'(w.sum));
          if (frame_exposure !== w.expo)
            flag_mismatch("frame_exposure", 64'(frame_exposure), 64'(w.expo));
          if (frame_noise !== w.noise)
            flag_mismatch("frame_noise", 64'(frame_noise), 64'(w.noise));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_EXPECTED) need_reg = cfg_data[EXP_W-1:0];
        else if (cfg_index == REG_TOLERANCE) tol_reg = cfg_data[TOL_W-1:0];
      end
      if (in_valid && in_ready) begin
        combine_word(arrival_time, subband, power, exposure, noise_flag, w);
        frame_words_due.insert(frame_words_due.size(), w);
      end
    end
    // Publish the table so the stimulus can finish open frames
    pending = frame_words_due.size();
    for (i = 0; i < 16; i++) begin
      open_valid[i] = slot_live[i];
      open_keys[i*TIME_W +: TIME_W] = slot_key[i];
      open_masks[i*16 +: 16] = slot_mask[i];
    end
  end

  initial begin
    fails = 0;
    pending = 0;
  end

endmodule

FILE: tb/testbench.sv
// Top of the combiner testbench: clock, reset, stimulus, receiver and watchdog.
// Depends on ttpc_pkg, ttpc_checker and the timestamp_tolerant_power_combiner RTL.
`timescale 1ns / 100ps

module testbench;
  import ttpc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic [TIME_W-1:0] arrival_time = '0;
  logic [SUB_W-1:0] subband = '0;
  logic [POW_W-1:0] power = '0;
  logic [EXPO_W-1:0] exposure = '0;
  logic [NOISE_W-1:0] noise_flag = '0;
  logic out_valid, out_ready = 1'b0;
  logic [2:0] status;
  logic [TIME_W-1:0] frame_time;
  logic [SUM_W-1:0] frame_power;
  logic [EXPO_W-1:0] frame_exposure;
  logic [NOISE_W-1:0] frame_noise;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_EXPECTED;
  logic [CFG_W-1:0] cfg_data = '0;

  int fails, pending;
  logic [15:0] open_valid;
  logic [16*TIME_W-1:0] open_keys;
  logic [16*16-1:0] open_masks;

  bit quiet = 0;
  bit hold_req = 0;
  int words_sent = 0, words_seen = 0, reg_writes = 0, idle_run = 0;
  logic [TIME_W-1:0] base_times [8];
  int exp_set [7] = '{2, 16, 0, 31, 5, 1, 12};
  int tol_set [7] = '{1000, 1048575, 0, 5000, 1000000, 200, 1};

  always #2 clk = ~clk;

  timestamp_tolerant_power_combiner DUT (.*);

  ttpc_checker checker_i (.*);

  // Offer one word, idling first at random
  task automatic send_word(input logic [TIME_W-1:0] t, input logic [SUB_W-1:0] sb,
                           input logic [POW_W-1:0] pw, input logic [EXPO_W-1:0] ex,
                           input logic [NOISE_W-1:0] nf);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 10) gap = int'($urandom_range(1, 4));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    arrival_time <= t; subband <= sb; power <= pw; exposure <= ex; noise_flag <= nf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [POW_W-1:0] pick_power();
    int r;
    r = int'($urandom_range(99));
    if (r < 10) return '1;
    if (r < 15) return '0;
    return $urandom;
  endfunction

  // Stop offering and wait for every outstanding result, then for the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // One register write, then the write port goes quiet before the task returns
  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Complete every open frame: expect one more subband than the fullest frame holds,
  // then send each frame just enough missing subbands
  task automatic finish_open_frames();
    logic [15:0] live;
    logic [16*TIME_W-1:0] keys;
    logic [16*16-1:0] masks;
    int i, s, top, left;
    drain();
    live = open_valid; keys = open_keys; masks = open_masks;
    top = 1;
    for (i = 0; i < 16; i++)
      if (live[i] && int'($countones(masks[i*16 +: 16])) + 1 > top)
        top = int'($countones(masks[i*16 +: 16])) + 1;
    if (top > 16) top = 16;
    write_reg(REG_EXPECTED, CFG_W'(top));
    for (i = 0; i < 16; i++) begin
      if (live[i]) begin
        left = top - int'($countones(masks[i*16 +: 16]));
        for (s = 0; s < 16; s++) begin
          if (left > 0 && !masks[i*16 + s]) begin
            send_word(keys[i*TIME_W +: TIME_W], SUB_W'(s), pick_power(), $urandom,
                      NOISE_W'($urandom_range(255)));
            left--;
          end
        end
      end
    end
    drain();
  endtask

  // Mostly clustered words around a few frame times, with noise and bad ids
  task automatic random_phase(input int n, input int tol, input bit pressure);
    int k, r, b;
    logic [TIME_W-1:0] t, off;
    logic [SUB_W-1:0] sb;
    for (k = 0; k < 8; k++) base_times[k] = {$urandom, $urandom};
    for (k = 0; k < n; k++) begin
      if (pressure && k == 30) hold_req = 1;
      if (pressure && k == 60) drain();
      quiet = pressure && k >= 60;
      r = int'($urandom_range(99));
      b = int'($urandom_range(7));
      sb = SUB_W'($urandom_range(15));
      if (r < 8) begin
        t = {$urandom, $urandom};
        sb = ($urandom_range(3) == 0) ? 16'hFFFF : SUB_W'($urandom_range(16, 65535));
      end else if (r < 15) begin
        t = {$urandom, $urandom};
      end else if (r < 20) begin
        off = TIME_W'(tol) + TIME_W'($urandom_range(1, 50));
        t = $urandom_range(1) ? base_times[b] + off : base_times[b] - off;
      end else begin
        off = TIME_W'($urandom_range(tol / 2));
        t = $urandom_range(1) ? base_times[b] + off : base_times[b] - off;
      end
      if ($urandom_range(99) < 3) base_times[b] = {$urandom, $urandom};
      send_word(t, sb, pick_power(), $urandom, NOISE_W'($urandom_range(255)));
    end
    quiet = 0;
  endtask

  // Stimulus
  initial begin
    int p, k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: eight subbands, tolerance 1000
    send_word(64'd0, 16'd0, 32'd0, 32'd0, 8'd0);
    send_word(64'd1000, 16'd0, 32'd5, 32'd5, 8'd5);    // duplicate at the tolerance edge
    send_word('1, 16'd15, '1, '1, 8'hFF);
    send_word(64'hFFFF_FFFF_FFFF_FFFF - 64'd1000, 16'd14, '1, 32'd0, 8'd0);
    send_word(64'd0, 16'd16, 32'd1, 32'd1, 8'd1);       // bad ids
    send_word(64'd5, 16'hFFFF, 32'd1, 32'd1, 8'd1);
    send_word(64'd1001, 16'd3, 32'd7, 32'd7, 8'd7);     // just out of tolerance: new frame
    send_word(64'd500, 16'd1, 32'd9, 32'd9, 8'd9);      // nearest later key wins
    for (k = 1; k < 8; k++)                             // complete the frame at zero
      send_word(64'd0, SUB_W'(k), '1, 32'd3, 8'd3);

    // Fill the table with tolerance zero, then overflow it
    drain();
    write_reg(REG_EXPECTED, CFG_W'(16));
    write_reg(REG_TOLERANCE, CFG_W'(0));
    for (k = 0; k < 15; k++)
      send_word(TIME_W'(20000 + k * 10), 16'd3, POW_W'(k), EXPO_W'(k), NOISE_W'(k));

    // Single-subband frames complete even with a full table
    drain();
    write_reg(REG_EXPECTED, CFG_W'(1));
    send_word(64'd30000, 16'd2, 32'd77, 32'd8, 8'd9);
    finish_open_frames();

    for (p = 0; p < 7; p++) begin
      write_reg(REG_EXPECTED, CFG_W'(exp_set[p]));
      write_reg(REG_TOLERANCE, CFG_W'(tol_set[p]));
      random_phase(PHASE_WORDS, tol_set[p], p == 0);
      finish_open_frames();
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d words over %0d register writes; %0d results checked.",
             words_sent, reg_writes, words_seen);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random stalls, quiet stretches and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  // Watchdog on cycles in which no word is accepted and no result is taken
  always @(posedge clk) begin
    if (out_valid && out_ready && !rst) words_seen++;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
